// File: src/lffsa_pkg.sv
// shared types and constants of the liveness first-fit slot allocator
package lffsa_pkg;

   localparam int MODE_W     = 2;
   localparam int VID_W      = 10;
   localparam int ORD_W      = 10;
   localparam int SIZE_W     = 32;
   localparam int FREE_W     = 11;
   localparam int SLOT_W     = 9;
   localparam int SCNT_W     = 10;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   localparam logic [MODE_W-1:0] MODE_START = 2'd0;
   localparam logic [MODE_W-1:0] MODE_USE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [ORD_W-1:0] order;
   } use_entry_type;

   typedef struct packed {
      logic [FREE_W-1:0] free_order;
      logic [SIZE_W-1:0] capacity;
   } slot_entry_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_USE    = 6'b000100,
      ST_LOOKUP = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

endpackage

// File: src/liveness_first_fit_slot_allocator_unit.sv
// top level of the liveness first-fit slot allocator
//
//   channel  direction  tdata (low bit up)                tuser
//   req      in         value_id, order, size_elems       mode
//   rsp      out        slot, slot_count                  no_slot
//
// start: clearing pass over the last-use memory, no word out
// use: read, then compare and write back one last-use entry
// allocate: the slot table is scanned one entry per cycle
// reset starts the same clearing pass (req_tready low)
// a result waits in the output register while the next word is taken; an
// allocation holds in its last step until that register is free
module liveness_first_fit_slot_allocator_unit #(
   parameter int SLOT_COUNT = 512,
   parameter int ID_COUNT   = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lffsa_pkg::REQ_DATA_W-1:0] req_tdata,  // value_id, order, size_elems, pad
   input  logic [lffsa_pkg::MODE_W-1:0]     req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lffsa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // slot, slot_count, pad
   output logic [0:0]                       rsp_tuser   // no_slot
);
   localparam int VA_W  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
   localparam int SA_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int PAD_W = lffsa_pkg::RSP_DATA_W - lffsa_pkg::SLOT_W - lffsa_pkg::SCNT_W;

   lffsa_pkg::state_type state_ff, state_in;

   logic [VA_W-1:0]                clr_ff, clr_in;
   logic [VA_W-1:0]                vaddr_ff, vaddr_in;
   logic                           vid_ok_ff, vid_ok_in;
   logic [lffsa_pkg::ORD_W-1:0]    ord_ff, ord_in;
   logic [lffsa_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [lffsa_pkg::FREE_W-1:0]   free_ff, free_in;
   logic [CNT_W-1:0]               open_ff, open_in;
   logic [CNT_W-1:0]               scan_ff, scan_in;
   logic [CNT_W-1:0]               chk_ff, chk_in;
   logic                           chk_vld_ff, chk_vld_in;
   logic [lffsa_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic                           res_none_ff, res_none_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [lffsa_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                           rsp_none_ff, rsp_none_in;
   logic [lffsa_pkg::SCNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic                           req_fire;
   logic [lffsa_pkg::VID_W-1:0]    req_vid;
   logic [lffsa_pkg::ORD_W-1:0]    req_ord;
   logic [lffsa_pkg::SIZE_W-1:0]   req_size;
   logic [lffsa_pkg::ORD_W-1:0]    eff_last;
   logic                           issue;
   logic                           hit;
   logic                           scan_end;

   logic                           v_we;
   logic [VA_W-1:0]                v_waddr;
   lffsa_pkg::use_entry_type       v_wdata;
   lffsa_pkg::use_entry_type       v_rdata;

   logic                           s_we;
   logic [SA_W-1:0]                s_waddr;
   lffsa_pkg::slot_entry_type      s_wdata;
   lffsa_pkg::slot_entry_type      s_rdata;

   assign req_vid    = req_tdata[9:0];
   assign req_ord    = req_tdata[19:10];
   assign req_size   = req_tdata[51:20];
   assign req_tready = (state_ff == lffsa_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_cnt_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_none_ff;

   lffsa_value_store #(.DEPTH(ID_COUNT)) u_value_store (
      .clock   (clock),
      .rd_addr (VA_W'(req_vid)),
      .rd_data (v_rdata),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata)
   );

   lffsa_slot_table #(.DEPTH(SLOT_COUNT)) u_slot_table (
      .clock   (clock),
      .rd_addr (scan_ff[SA_W-1:0]),
      .rd_data (s_rdata),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata)
   );

   // effective last use, clamped to the defining order
   assign eff_last = (vid_ok_ff && v_rdata.valid && (v_rdata.order > ord_ff)) ?
                     v_rdata.order : ord_ff;

   assign issue    = (scan_ff < open_ff);
   assign hit      = chk_vld_ff && (s_rdata.free_order <= {1'b0, ord_ff}) &&
                     (s_rdata.capacity >= size_ff);
   assign scan_end = !chk_vld_ff && !issue;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      vaddr_in    = vaddr_ff;
      vid_ok_in   = vid_ok_ff;
      ord_in      = ord_ff;
      size_in     = size_ff;
      free_in     = free_ff;
      open_in     = open_ff;
      scan_in     = scan_ff;
      chk_in      = chk_ff;
      chk_vld_in  = chk_vld_ff;
      res_slot_in = res_slot_ff;
      res_none_in = res_none_ff;
      rsp_vld_in  = rsp_vld_ff & ~rsp_tready;
      rsp_slot_in = rsp_slot_ff;
      rsp_none_in = rsp_none_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      v_we        = 1'b0;
      v_waddr     = vaddr_ff;
      v_wdata     = '{valid: 1'b1, order: ord_ff};
      s_we        = 1'b0;
      s_waddr     = chk_ff[SA_W-1:0];
      s_wdata     = '{free_order: free_ff, capacity: s_rdata.capacity};

      case (state_ff)
         lffsa_pkg::ST_CLEAR: begin
            v_we    = 1'b1;
            v_waddr = clr_ff;
            v_wdata = '{valid: 1'b0, order: '0};
            if (clr_ff == VA_W'(ID_COUNT - 1)) begin
               clr_in   = '0;
               state_in = lffsa_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         lffsa_pkg::ST_IDLE: begin
            if (req_fire) begin
               vaddr_in  = VA_W'(req_vid);
               vid_ok_in = (32'(req_vid) < 32'(ID_COUNT));
               ord_in    = req_ord;
               size_in   = req_size;
               case (req_tuser)
                  lffsa_pkg::MODE_START: begin
                     open_in  = '0;
                     clr_in   = '0;
                     state_in = lffsa_pkg::ST_CLEAR;
                  end
                  lffsa_pkg::MODE_USE: begin
                     state_in = lffsa_pkg::ST_USE;
                  end
                  lffsa_pkg::MODE_ALLOC: begin
                     state_in = lffsa_pkg::ST_LOOKUP;
                  end
                  default: begin
                     state_in = lffsa_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         lffsa_pkg::ST_USE: begin
            v_we     = vid_ok_ff && (!v_rdata.valid || (ord_ff > v_rdata.order));
            state_in = lffsa_pkg::ST_IDLE;
         end
         lffsa_pkg::ST_LOOKUP: begin
            free_in    = {1'b0, eff_last} + 1'b1;
            scan_in    = '0;
            chk_vld_in = 1'b0;
            state_in   = lffsa_pkg::ST_SCAN;
         end
         lffsa_pkg::ST_SCAN: begin
            if (hit) begin
               s_we        = 1'b1;
               res_slot_in = lffsa_pkg::SLOT_W'(chk_ff);
               res_none_in = 1'b0;
               state_in    = lffsa_pkg::ST_DONE;
            end else if (scan_end) begin
               if (open_ff < CNT_W'(SLOT_COUNT)) begin
                  s_we        = 1'b1;
                  s_waddr     = open_ff[SA_W-1:0];
                  s_wdata     = '{free_order: free_ff, capacity: size_ff};
                  res_slot_in = lffsa_pkg::SLOT_W'(open_ff);
                  res_none_in = 1'b0;
                  open_in     = open_ff + 1'b1;
               end else begin
                  res_slot_in = '0;
                  res_none_in = 1'b1;
               end
               state_in = lffsa_pkg::ST_DONE;
            end else begin
               chk_in     = scan_ff;
               chk_vld_in = issue;
               if (issue) begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         lffsa_pkg::ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_slot_in = res_slot_ff;
               rsp_none_in = res_none_ff;
               rsp_cnt_in  = lffsa_pkg::SCNT_W'(open_ff);
               state_in    = lffsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lffsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lffsa_pkg::ST_CLEAR;
         clr_ff     <= '0;
         open_ff    <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         open_ff    <= open_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      vaddr_ff    <= vaddr_in;
      vid_ok_ff   <= vid_ok_in;
      ord_ff      <= ord_in;
      size_ff     <= size_in;
      free_ff     <= free_in;
      scan_ff     <= scan_in;
      chk_ff      <= chk_in;
      res_slot_ff <= res_slot_in;
      res_none_ff <= res_none_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_none_ff <= rsp_none_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

endmodule

// File: src/lffsa_value_store.sv
// last-use memory, one entry per value id, registered read
module lffsa_value_store #(
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic [AW-1:0]            rd_addr,
   output lffsa_pkg::use_entry_type rd_data,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  lffsa_pkg::use_entry_type wr_data
);

   lffsa_pkg::use_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/lffsa_slot_table.sv
// slot memory holding free order and capacity per slot, registered read
module lffsa_slot_table #(
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic [AW-1:0]             rd_addr,
   output lffsa_pkg::slot_entry_type rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  lffsa_pkg::slot_entry_type wr_data
);

   lffsa_pkg::slot_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/lffsa_checker.sv
// port checker for the slot allocator and its bind to the top level
module lffsa_checker #(
   parameter int SLOT_COUNT = 512
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [lffsa_pkg::MODE_W-1:0]     req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lffsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                       rsp_tuser
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // reset starts the clearing pass with nothing offered
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ports active right after reset");

   // no slot means slot field zero and every slot open
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[8:0] == 9'd0 &&
         rsp_tdata[18:9] == lffsa_pkg::SCNT_W'(SLOT_COUNT))
      else $error("no_slot with free slots or nonzero slot");

   // an assigned slot is one of the open slots
   a_slot_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && (SLOT_COUNT <= 512) |->
         {1'b0, rsp_tdata[8:0]} < rsp_tdata[18:9])
      else $error("assigned slot not below slot count");

   // the next word is not taken while an allocation result is pending
   a_no_accept_late: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == lffsa_pkg::MODE_ALLOC |=> !req_tready)
      else $error("word accepted during allocation");

endmodule

bind liveness_first_fit_slot_allocator_unit lffsa_checker #(
   .SLOT_COUNT(SLOT_COUNT)
) u_lffsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: verif/slot_plan_checker.sv
// watches both channels, predicts every slot placement and compares the result words
`timescale 1ns / 1ps

module slot_plan_checker #(
   parameter int SLOT_COUNT = 512,
   parameter int ID_COUNT   = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [lffsa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [lffsa_pkg::MODE_W-1:0]     req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [lffsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [0:0]                       rsp_tuser,
   output int                               mismatch_count,
   output int                               words_owed
);

   typedef struct packed {
      logic [lffsa_pkg::SLOT_W-1:0] slot;
      logic                         no_slot;
      logic [lffsa_pkg::SCNT_W-1:0] slot_count;
   } placement_type;

   logic [lffsa_pkg::ORD_W-1:0]  last_order [ID_COUNT];
   logic                         use_seen [ID_COUNT];
   logic [lffsa_pkg::FREE_W-1:0] free_from [SLOT_COUNT];
   logic [lffsa_pkg::SIZE_W-1:0] capacity [SLOT_COUNT];
   int unsigned                  slots_open;
   placement_type                placement_q [$];

   function automatic placement_type place_value(input logic [lffsa_pkg::VID_W-1:0] vid,
                                                 input logic [lffsa_pkg::ORD_W-1:0] ord,
                                                 input logic [lffsa_pkg::SIZE_W-1:0] size);
      placement_type                pl;
      logic [lffsa_pkg::ORD_W-1:0]  last;
      logic [lffsa_pkg::FREE_W-1:0] free_at;
      int                           hit;
      last = ord;
      if (vid < ID_COUNT && use_seen[vid] && last_order[vid] > ord) begin
         last = last_order[vid];
      end
      free_at = {1'b0, last} + 1'b1;
      hit = -1;
      for (int s = 0; s < slots_open && s < SLOT_COUNT; s++) begin
         if (free_from[s] <= {1'b0, ord} && capacity[s] >= size) begin
            hit = s;
            break;
         end
      end
      pl = '0;
      if (hit >= 0) begin
         free_from[hit] = free_at;
         pl.slot = hit[lffsa_pkg::SLOT_W-1:0];
      end else if (slots_open < SLOT_COUNT) begin
         free_from[slots_open] = free_at;
         capacity[slots_open] = size;
         pl.slot = slots_open[lffsa_pkg::SLOT_W-1:0];
         slots_open++;
      end else begin
         pl.no_slot = 1'b1;
      end
      pl.slot_count = slots_open[lffsa_pkg::SCNT_W-1:0];
      return pl;
   endfunction

   always @(posedge clock) begin
      logic [lffsa_pkg::VID_W-1:0]  vid;
      logic [lffsa_pkg::ORD_W-1:0]  ord;
      logic [lffsa_pkg::SIZE_W-1:0] size;
      placement_type                want;
      if (reset) begin
         for (int v = 0; v < ID_COUNT; v++) begin
            use_seen[v] = 1'b0;
         end
         slots_open = 0;
         mismatch_count = 0;
         placement_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            vid  = req_tdata[lffsa_pkg::VID_W-1:0];
            ord  = req_tdata[lffsa_pkg::VID_W +: lffsa_pkg::ORD_W];
            size = req_tdata[lffsa_pkg::VID_W+lffsa_pkg::ORD_W +: lffsa_pkg::SIZE_W];
            case (req_tuser)
               lffsa_pkg::MODE_START: begin
                  for (int v = 0; v < ID_COUNT; v++) begin
                     use_seen[v] = 1'b0;
                  end
                  slots_open = 0;
               end
               lffsa_pkg::MODE_USE: begin
                  if (vid < ID_COUNT && (!use_seen[vid] || ord > last_order[vid])) begin
                     last_order[vid] = ord;
                     use_seen[vid] = 1'b1;
                  end
               end
               lffsa_pkg::MODE_ALLOC: placement_q.push_back(place_value(vid, ord, size));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (placement_q.size() == 0) begin
               $error("unexpected result word: slot %0d, no_slot %0d, slot_count %0d",
                      rsp_tdata[lffsa_pkg::SLOT_W-1:0], rsp_tuser[0],
                      rsp_tdata[lffsa_pkg::SLOT_W +: lffsa_pkg::SCNT_W]);
               mismatch_count++;
            end else begin
               want = placement_q.pop_front();
               if (rsp_tdata[lffsa_pkg::SLOT_W-1:0] !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot,
                         rsp_tdata[lffsa_pkg::SLOT_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== want.no_slot) begin
                  $error("no_slot: expected %0d, got %0d", want.no_slot, rsp_tuser[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[lffsa_pkg::SLOT_W +: lffsa_pkg::SCNT_W] !== want.slot_count) begin
                  $error("slot_count: expected %0d, got %0d", want.slot_count,
                         rsp_tdata[lffsa_pkg::SLOT_W +: lffsa_pkg::SCNT_W]);
                  mismatch_count++;
               end
            end
         end
      end
      words_owed = placement_q.size();
   end

endmodule

// File: verif/tb_top.sv
// top of the slot allocator testbench: clock, reset, stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb_top;

   localparam logic [lffsa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CLEAR_CYCLES = 1024;
   localparam int FILL_ALLOCS  = 524;
   localparam int EARLY_ITEMS  = 350;
   localparam int TOTAL_ITEMS  = 1170;
   localparam int HOLD_START   = 6000;
   localparam int HOLD_CYCLES  = 3000;

   typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_style_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [lffsa_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [lffsa_pkg::MODE_W-1:0]     req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [lffsa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                       rsp_tuser;
   int                               mismatch_count;
   int                               words_owed;
   int                               burst_left;
   int                               items_sent;

   liveness_first_fit_slot_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   slot_plan_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .words_owed     (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [lffsa_pkg::SIZE_W-1:0] random_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom;
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   task automatic send_word(input logic [lffsa_pkg::MODE_W-1:0] mode,
                            input logic [lffsa_pkg::VID_W-1:0] vid,
                            input logic [lffsa_pkg::ORD_W-1:0] ord,
                            input logic [lffsa_pkg::SIZE_W-1:0] size);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, size, ord, vid};
      do @(posedge clock); while (!req_tready);
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // one plan: ids from a small window, defining orders mostly rising
   task automatic run_plan(input int steps, input bit with_start);
      logic [lffsa_pkg::VID_W-1:0] id_base;
      int                          ord;
      int                          use_ord;
      int                          pick;
      id_base = lffsa_pkg::VID_W'($urandom);
      ord = $urandom_range(0, 700);
      if (with_start) begin
         send_word(lffsa_pkg::MODE_START, lffsa_pkg::VID_W'($urandom),
                   lffsa_pkg::ORD_W'($urandom), $urandom);
      end
      for (int k = 0; k < steps; k++) begin
         ord = ord + $urandom_range(0, 12);
         if (ord > 1023) ord = $urandom_range(0, 1023);
         use_ord = ord + $urandom_range(0, 60);
         if (use_ord > 1023) use_ord = 1023;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_word(lffsa_pkg::MODE_USE, lffsa_pkg::VID_W'(id_base + $urandom_range(0, 15)),
                      lffsa_pkg::ORD_W'(use_ord), $urandom);
         end else if (pick < 93) begin
            send_word(lffsa_pkg::MODE_ALLOC, lffsa_pkg::VID_W'(id_base + $urandom_range(0, 15)),
                      lffsa_pkg::ORD_W'(ord), random_size());
         end else if (pick < 97) begin
            send_word(MODE_UNUSED, lffsa_pkg::VID_W'($urandom), lffsa_pkg::ORD_W'($urandom),
                      $urandom);
         end else begin
            send_word(lffsa_pkg::MODE_W'($urandom_range(0, 2)), lffsa_pkg::VID_W'($urandom),
                      lffsa_pkg::ORD_W'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      ready_style_type style;
      int              style_left;
      int              hold_left;
      int              cycle_no;
      rsp_tready <= 1'b0;
      style = READY_ALWAYS;
      style_left = 0;
      hold_left = 0;
      cycle_no = 0;
      forever begin
         @(negedge clock);
         cycle_no++;
         if (cycle_no == HOLD_START) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = ready_style_type'($urandom_range(0, 2));
               style_left = $urandom_range(20, 300);
            end
            style_left--;
            case (style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= ($urandom_range(0, 1) == 1);
               default:      rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= lffsa_pkg::MODE_START;
      burst_left = 0;
      items_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, clamping, reuse, zero size, ignored mode
      send_word(lffsa_pkg::MODE_START, '0, '0, '0);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd5, 10'd0, 32'd0);
      send_word(lffsa_pkg::MODE_USE, 10'd1023, 10'd1023, '1);
      send_word(lffsa_pkg::MODE_USE, 10'd1023, 10'd3, '0);
      send_word(lffsa_pkg::MODE_USE, 10'd0, 10'd0, '0);
      send_word(lffsa_pkg::MODE_USE, 10'd0, 10'd7, '0);
      send_word(MODE_UNUSED, '1, '1, '1);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd1023, 10'd1023, '1);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd0, 10'd2, 32'd100);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd9, 10'd8, 32'd0);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd9, 10'd8, 32'd50);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd9, 10'd0, '1);
      send_word(lffsa_pkg::MODE_USE, 10'd512, 10'd600, '0);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd512, 10'd10, 32'd1);
      send_word(lffsa_pkg::MODE_START, '1, '1, '1);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd1023, 10'd4, 32'hFFFF_FFFF);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd512, 10'd5, 32'h8000_0000);
      send_word(lffsa_pkg::MODE_ALLOC, 10'd0, 10'd1023, 32'h7FFF_FFFF);

      while (items_sent < EARLY_ITEMS) begin
         run_plan($urandom_range(5, 40), $urandom_range(0, 9) != 0);
      end

      // fill every slot, then run out, then reuse late
      send_word(lffsa_pkg::MODE_START, lffsa_pkg::VID_W'($urandom),
                lffsa_pkg::ORD_W'($urandom), $urandom);
      for (int k = 0; k < FILL_ALLOCS; k++) begin
         send_word(lffsa_pkg::MODE_ALLOC, lffsa_pkg::VID_W'($urandom), 10'd0, random_size());
      end
      repeat (6) begin
         send_word(lffsa_pkg::MODE_ALLOC, lffsa_pkg::VID_W'($urandom), 10'd1023,
                   $urandom_range(0, 64));
      end

      while (items_sent < TOTAL_ITEMS) begin
         run_plan($urandom_range(5, 40), $urandom_range(0, 9) != 0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (words_owed == 0);
      repeat (CLEAR_CYCLES + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
